### hw/rtl/bbd_pkg.sv
// Shared types and constants for the bilinear Bayer demosaic core.
// Used by the line store, window cell, interpolation and top-level modules.
// No dependencies.
package bbd_pkg;

    // One raw sample or one output color channel.
    localparam int PIX_W = 8;
    typedef logic [PIX_W-1:0] pix_t;

    // Configuration register widths and the write data width.
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_ADDR_W      = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Number of cells in the window chain.
    localparam int WIN_COLS = 3;

    // One window column: three vertically adjacent samples, oldest row on top.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // Position flags of the pixel at the window center.
    typedef struct packed {
        logic row_odd;
        logic col_odd;
        logic has_top;
        logic has_bot;
        logic has_left;
        logic has_right;
        logic frame_end;
    } pos_t;

    // Interpolated output pixel.
    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
    } rgb_t;

endpackage

### hw/rtl/bbd_line_store.sv
// Single line store: one write port and one registered read port.
// Depends on bbd_pkg for the sample type.
module bbd_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bbd_pkg::pix_t       wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bbd_pkg::pix_t       rd_data
);

    bbd_pkg::pix_t mem [DEPTH];
    bbd_pkg::pix_t rd_data_reg;

    // Write on a transfer; read the addressed entry every cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/bbd_window_cell.sv
// One column cell of the 3x3 window chain; passes its column to the next cell.
// Depends on bbd_pkg for the column type.
module bbd_window_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  bbd_pkg::col_t col_in,
    output bbd_pkg::col_t col_out
);

    bbd_pkg::col_t col_reg;

    // Take the neighbor's column on every accepted input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

### hw/rtl/bbd_interp.sv
// Bilinear interpolation of the missing colors at the window center.
// Depends on bbd_pkg for the column, position and pixel types.
module bbd_interp (
    input  bbd_pkg::col_t win_left,
    input  bbd_pkg::col_t win_center,
    input  bbd_pkg::col_t win_right,
    input  bbd_pkg::pos_t pos,
    output bbd_pkg::rgb_t rgb
);

    // Division by three as a multiply by 683/2048, exact for sums up to 765.
    localparam logic [9:0] Recip3      = 10'd683;
    localparam int         Recip3Shift = 11;

    logic [9:0] vert_sum, horiz_sum, cross_sum, diag_sum;
    logic [2:0] vert_cnt, horiz_cnt, cross_cnt, diag_cnt;
    bbd_pkg::pix_t vert_mean, horiz_mean, cross_mean, diag_mean;

    function automatic logic [9:0] masked(bbd_pkg::pix_t p, logic en);
        return en ? 10'(p) : 10'd0;
    endfunction

    function automatic bbd_pkg::pix_t mean_of(logic [9:0] sum, logic [2:0] cnt);
        logic [19:0] prod;
        bbd_pkg::pix_t res;
        prod = 20'(sum) * 20'(Recip3);
        unique case (cnt)
            3'd1:    res = sum[7:0];
            3'd2:    res = sum[8:1];
            3'd3:    res = prod[Recip3Shift +: bbd_pkg::PIX_W];
            3'd4:    res = sum[9:2];
            default: res = '0;
        endcase
        return res;
    endfunction

    // Neighbor sums over the samples that lie inside the frame.
    always_comb begin
        vert_sum  = masked(win_center.top, pos.has_top) + masked(win_center.bot, pos.has_bot);
        vert_cnt  = 3'(pos.has_top) + 3'(pos.has_bot);
        horiz_sum = masked(win_left.mid, pos.has_left) + masked(win_right.mid, pos.has_right);
        horiz_cnt = 3'(pos.has_left) + 3'(pos.has_right);
        cross_sum = vert_sum + horiz_sum;
        cross_cnt = vert_cnt + horiz_cnt;
        diag_sum  = masked(win_left.top,  pos.has_top && pos.has_left)
                  + masked(win_right.top, pos.has_top && pos.has_right)
                  + masked(win_left.bot,  pos.has_bot && pos.has_left)
                  + masked(win_right.bot, pos.has_bot && pos.has_right);
        diag_cnt  = 3'(pos.has_top && pos.has_left) + 3'(pos.has_top && pos.has_right)
                  + 3'(pos.has_bot && pos.has_left) + 3'(pos.has_bot && pos.has_right);
        vert_mean  = mean_of(vert_sum, vert_cnt);
        horiz_mean = mean_of(horiz_sum, horiz_cnt);
        cross_mean = mean_of(cross_sum, cross_cnt);
        diag_mean  = mean_of(diag_sum, diag_cnt);
    end

    // Pick the channel sources from the color of the center pixel.
    always_comb begin
        unique case ({pos.row_odd, pos.col_odd})
            2'b00: begin
                // Green on a green-blue row.
                rgb.red   = vert_mean;
                rgb.green = win_center.mid;
                rgb.blue  = horiz_mean;
            end
            2'b01: begin
                // Blue site.
                rgb.red   = diag_mean;
                rgb.green = cross_mean;
                rgb.blue  = win_center.mid;
            end
            2'b10: begin
                // Red site.
                rgb.red   = win_center.mid;
                rgb.green = cross_mean;
                rgb.blue  = diag_mean;
            end
            default: begin
                // Green on a red-green row.
                rgb.red   = horiz_mean;
                rgb.green = win_center.mid;
                rgb.blue  = vert_mean;
            end
        endcase
    end

endmodule

### hw/rtl/bayer_bilinear_demosaic_core.sv
// Bilinear Bayer demosaic core: accepts one raw sample per cycle when the output is not stalled.
// Results trail the input by image_width+1 transfers; an emitting transfer loads the window at
// its accepting edge; the output register then shows its result on m_tdata once pipe_en allows.
// One pixel per cycle when not stalled: each line store writes and reads once per transfer.
// Synchronous active-low reset restores 640x480, clears the position counters and the window;
// the line stores are not cleared. Uses bbd_pkg, bbd_line_store, bbd_window_cell, bbd_interp.
module bayer_bilinear_demosaic_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream. s_tdata: sample[7:0]. s_tuser: mode[0].
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic [0:0]                       s_tuser,
    // Output stream. m_tdata: red[7:0], green[15:8], blue[23:16]. m_tlast: frame_end.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,
    output logic                             m_tlast,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [bbd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RstWidth  = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
    localparam int RstHeight = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    logic [CW-1:0] last_col_reg, last_col_cfg;
    logic [RW-1:0] last_row_reg, last_row_cfg;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [1:0]    rows_seen_reg, rows_seen_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic pipe_en, accept, emit, out_last;
    logic win_valid_reg, m_valid_reg, m_last_reg;
    bbd_pkg::pos_t pos_now, pos_reg;
    bbd_pkg::rgb_t rgb_calc, m_data_reg;

    logic [bbd_pkg::CFG_WIDTH_BITS-1:0]  cfg_width_val;
    logic [bbd_pkg::CFG_HEIGHT_BITS-1:0] cfg_height_val;

    bbd_pkg::pix_t upper_rd, lower_rd;
    bbd_pkg::col_t new_col;
    bbd_pkg::col_t cell_in  [bbd_pkg::WIN_COLS];
    bbd_pkg::col_t cell_out [bbd_pkg::WIN_COLS];

    // Handshake: the pipeline moves when the output register is free or being taken.
    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = pipe_en;
    assign accept   = s_tvalid && pipe_en;

    // Clamp written dimensions to the supported range.
    assign cfg_width_val  = cfg_wdata[bbd_pkg::CFG_WIDTH_BITS-1:0];
    assign cfg_height_val = cfg_wdata[bbd_pkg::CFG_HEIGHT_BITS-1:0];

    always_comb begin
        if (cfg_width_val < bbd_pkg::CFG_WIDTH_BITS'(2)) begin
            last_col_cfg = CW'(1);
        end else if (32'(cfg_width_val) > 32'(MAX_WIDTH)) begin
            last_col_cfg = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_cfg = CW'(cfg_width_val - bbd_pkg::CFG_WIDTH_BITS'(1));
        end
        if (cfg_height_val < bbd_pkg::CFG_HEIGHT_BITS'(2)) begin
            last_row_cfg = RW'(1);
        end else if (32'(cfg_height_val) > 32'(MAX_HEIGHT)) begin
            last_row_cfg = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_cfg = RW'(cfg_height_val - bbd_pkg::CFG_HEIGHT_BITS'(1));
        end
    end

    // Configuration registers hold the last column and row indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= CW'(RstWidth - 1);
            last_row_reg <= RW'(RstHeight - 1);
        end else if (cfg_we) begin
            if (cfg_addr == bbd_pkg::CFG_IDX_WIDTH) begin
                last_col_reg <= last_col_cfg;
            end
            if (cfg_addr == bbd_pkg::CFG_IDX_HEIGHT) begin
                last_row_reg <= last_row_cfg;
            end
        end
    end

    // A result is due once a full line plus one sample has been taken.
    assign emit     = (rows_seen_reg == 2'd2) || (rows_seen_reg == 2'd1 && in_col_reg != '0);
    assign out_last = (out_row_reg == last_row_reg) && (out_col_reg == last_col_reg);

    // Position counters; a configuration write or the frame's last result restarts them.
    always_comb begin
        in_col_next    = in_col_reg;
        rows_seen_next = rows_seen_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        if (cfg_we) begin
            in_col_next    = '0;
            rows_seen_next = '0;
            out_col_next   = '0;
            out_row_next   = '0;
        end else if (accept) begin
            if (in_col_reg == last_col_reg) begin
                in_col_next = '0;
                if (rows_seen_reg != 2'd2) begin
                    rows_seen_next = rows_seen_reg + 2'd1;
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit) begin
                if (out_last) begin
                    in_col_next    = '0;
                    rows_seen_next = '0;
                    out_col_next   = '0;
                    out_row_next   = '0;
                end else if (out_col_reg == last_col_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            rows_seen_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end else begin
            in_col_reg    <= in_col_next;
            rows_seen_reg <= rows_seen_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
        end
    end

    // Line stores: lower holds the previous row, upper the row before it.
    // The read address runs one transfer ahead so the data is ready on acceptance.
    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_store_lower (
        .aclk    (aclk),
        .we      (accept),
        .wr_addr (in_col_reg),
        .wr_data (s_tdata),
        .rd_addr (in_col_next),
        .rd_data (lower_rd)
    );

    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_store_upper (
        .aclk    (aclk),
        .we      (accept),
        .wr_addr (in_col_reg),
        .wr_data (lower_rd),
        .rd_addr (in_col_next),
        .rd_data (upper_rd)
    );

    // Window chain: cell 0 holds the newest column, cell 1 the center, cell 2 the left.
    assign new_col = '{top: upper_rd, mid: lower_rd, bot: s_tdata};

    for (genvar i = 0; i < bbd_pkg::WIN_COLS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_in[i] = new_col;
        end else begin : g_link
            assign cell_in[i] = cell_out[i-1];
        end
        bbd_window_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .col_in   (cell_in[i]),
            .col_out  (cell_out[i])
        );
    end

    // Flags of the output pixel that the shifted window is centered on.
    always_comb begin
        pos_now.row_odd   = out_row_reg[0];
        pos_now.col_odd   = out_col_reg[0];
        pos_now.has_top   = out_row_reg != '0;
        pos_now.has_bot   = out_row_reg != last_row_reg;
        pos_now.has_left  = out_col_reg != '0;
        pos_now.has_right = out_col_reg != last_col_reg;
        pos_now.frame_end = out_last;
    end

    // Window stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            win_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg <= pos_now;
        end
    end

    bbd_interp u_interp (
        .win_left   (cell_out[2]),
        .win_center (cell_out[1]),
        .win_right  (cell_out[0]),
        .pos        (pos_reg),
        .rgb        (rgb_calc)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= win_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && win_valid_reg) begin
            m_data_reg <= rgb_calc;
            m_last_reg <= pos_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
